>>> sv/sgsg_pkg.sv
// shared types, constants and helpers for the scaled glyph span generator
`default_nettype none

package sgsg_pkg;

  localparam int GLYPH_WIDTH = 8;
  localparam int MASK_W      = 32;
  localparam int COORD_W     = 13;
  localparam int SCALE_W     = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INK_COLOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_CODE  = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_RST      = 3'd1;
  localparam logic [31:0]        INK_COLOR_RST  = 32'd0;
  localparam logic [7:0]         FIRST_CODE_RST = 8'd32;
  localparam logic [7:0]         LAST_CODE_RST  = 8'd126;

  // item actions
  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef struct packed {
    logic        action;
    logic        start_text;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  char_code;
    logic [7:0]  glyph_index;
    logic [3:0]  glyph_line;
    logic [7:0]  row_bits;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] span_x;
    logic [COORD_W-1:0] span_y;
    logic [MASK_W-1:0]  span_mask;
    logic [31:0]        span_color;
    logic               last_span;
  } out_item_t;

  typedef struct packed {
    logic mem_write;
    logic start_draw;
    logic scan;
    logic rewind;
    logic skip;
    logic load_mask;
    logic emit;
    logic row_inc;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic any_ink_nxt;
    logic rd_zero;
    logic row_last;
    logic rep_last;
    logic out_free;
  } dp_stat_t;

  // every set glyph bit, msb leftmost, becomes s adjacent mask bits
  function automatic logic [MASK_W-1:0] widen_row(input logic [7:0] bits,
                                                  input logic [SCALE_W-1:0] s);
    logic [MASK_W-1:0] m;
    int idx;
    m = '0;
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      for (int k = 0; k < 8; k++) begin
        idx = c * int'(s) + k;
        if (k < int'(s) && idx < MASK_W && bits[GLYPH_WIDTH-1-c]) begin
          m[idx[4:0]] = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> sv/sgsg_dp.sv
// datapath: config registers, glyph store, row scan, span build and output register
`default_nettype none

module sgsg_dp
  import sgsg_pkg::*;
#(
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256,
  parameter int MAX_SCALE    = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_item_t              in_data,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   st,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(GLYPH_HEIGHT);
  localparam logic [RW-1:0] ROW_END = RW'(GLYPH_HEIGHT - 1);

  logic [SCALE_W-1:0] scale_r;
  logic [31:0]        ink_r;
  logic [7:0]         first_r;
  logic [7:0]         last_r;

  logic [7:0]         mem [DEPTH];
  logic [7:0]         rd_data_r;
  logic [AW-1:0]      base_r;
  logic [RW-1:0]      row_r;
  logic [RW-1:0]      chk_row_r;
  logic               chk_vld_r;
  logic [RW-1:0]      last_row_r;
  logic               any_r;
  logic [SCALE_W-1:0] rep_r;
  logic [MASK_W-1:0]  mask_r;
  logic [COORD_W-1:0] line_r;
  logic [COORD_W-1:0] cursor_x_r;
  logic [COORD_W-1:0] cursor_y_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [SCALE_W-1:0] eff_s;
  logic               wr_ok;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         glyph;
  logic [7:0]         code_off;
  logic               rd_nz;

  always_comb begin
    eff_s = scale_r;
    if (eff_s == '0) begin
      eff_s = SCALE_W'(1);
    end else if (int'(eff_s) > MAX_SCALE) begin
      eff_s = SCALE_W'(MAX_SCALE);
    end
  end

  assign wr_ok   = (int'(in_data.glyph_index) < GLYPH_COUNT) &&
                   (int'(in_data.glyph_line) < GLYPH_HEIGHT);
  assign wr_addr = AW'(int'(in_data.glyph_index) * GLYPH_HEIGHT + int'(in_data.glyph_line));
  assign rd_addr = base_r + AW'(row_r);
  assign rd_nz   = (rd_data_r != 8'd0);

  // codes outside the configured range fall back to glyph 0
  assign code_off = in_data.char_code - first_r;
  always_comb begin
    glyph = 8'd0;
    if (in_data.char_code >= first_r && in_data.char_code <= last_r &&
        int'(code_off) < GLYPH_COUNT) begin
      glyph = code_off;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write && wr_ok) begin
      mem[wr_addr] <= in_data.row_bits;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
      ink_r   <= INK_COLOR_RST;
      first_r <= FIRST_CODE_RST;
      last_r  <= LAST_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE:      scale_r <= cfg_data[SCALE_W-1:0];
        REG_INK_COLOR:  ink_r   <= cfg_data[31:0];
        REG_FIRST_CODE: first_r <= cfg_data[7:0];
        REG_LAST_CODE:  last_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      chk_vld_r   <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start_draw) begin
        if (in_data.start_text) begin
          cursor_x_r <= COORD_W'(in_data.pos_x);
          cursor_y_r <= COORD_W'(in_data.pos_y);
        end
        chk_vld_r <= 1'b0;
        any_r     <= 1'b0;
      end
      if (cmd.scan) begin
        chk_vld_r <= 1'b1;
        if (chk_vld_r && rd_nz) begin
          any_r <= 1'b1;
        end
      end
      if (cmd.advance) begin
        cursor_x_r <= cursor_x_r + COORD_W'({eff_s, 3'b000});
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start_draw) begin
      base_r <= AW'(int'(glyph) * GLYPH_HEIGHT);
      row_r  <= '0;
      line_r <= in_data.start_text ? COORD_W'(in_data.pos_y) : cursor_y_r;
    end
    if (cmd.scan) begin
      chk_row_r <= row_r;
      if (row_r != ROW_END) begin
        row_r <= row_r + RW'(1);
      end
      if (chk_vld_r && rd_nz) begin
        last_row_r <= chk_row_r;
      end
    end
    if (cmd.rewind) begin
      row_r <= '0;
    end
    if (cmd.skip) begin
      row_r  <= row_r + RW'(1);
      line_r <= line_r + COORD_W'(eff_s);
    end
    if (cmd.load_mask) begin
      mask_r <= widen_row(rd_data_r, eff_s);
      rep_r  <= '0;
    end
    if (cmd.emit) begin
      out_data_r <= '{span_x:     cursor_x_r,
                      span_y:     line_r,
                      span_mask:  mask_r,
                      span_color: ink_r,
                      last_span:  st.row_last && st.rep_last};
      line_r <= line_r + COORD_W'(1);
      rep_r  <= rep_r + SCALE_W'(1);
    end
    if (cmd.row_inc) begin
      row_r <= row_r + RW'(1);
    end
  end

  always_comb begin
    st.scan_done   = chk_vld_r && (chk_row_r == ROW_END);
    st.any_ink_nxt = any_r || rd_nz;
    st.rd_zero     = !rd_nz;
    st.row_last    = (row_r == last_row_r);
    st.rep_last    = (rep_r == eff_s - SCALE_W'(1));
    st.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("span loaded over an untaken beat");

  a_skip_before_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.skip |-> (any_r && row_r != last_row_r))
    else $error("blank row skipped at or past the last inked row");

  a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.advance && !cmd.start_draw) |=> $stable(cursor_x_r))
    else $error("cursor moved outside draw start or advance");

endmodule

`default_nettype wire

>>> sv/sgsg_ctrl.sv
// controller: sequences load, row scan, row fetch, span emission and cursor advance
`default_nettype none

module sgsg_ctrl
  import sgsg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_action,
  output logic          in_ready,
  input  wire dp_stat_t st,
  output dp_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_FETCH = 6'b000100,
    S_TEST  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_ADV   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_LOAD) begin
            cmd.mem_write = 1'b1;
          end else begin
            cmd.start_draw = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      // find the last inked row so the final span can be flagged
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          cmd.rewind = 1'b1;
          state_nxt  = st.any_ink_nxt ? S_FETCH : S_ADV;
        end
      end
      S_FETCH: begin
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (st.rd_zero) begin
          cmd.skip  = 1'b1;
          state_nxt = S_FETCH;
        end else begin
          cmd.load_mask = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.rep_last) begin
            if (st.row_last) begin
              state_nxt = S_ADV;
            end else begin
              cmd.row_inc = 1'b1;
              state_nxt   = S_FETCH;
            end
          end
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_write || cmd.start_draw) |-> (in_ready && in_valid))
    else $error("store write or draw start without an input beat");

  a_last_span_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && st.rep_last && st.row_last) |=> (cmd.advance && !in_ready))
    else $error("final span not followed by cursor advance");

  a_advance_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> in_ready)
    else $error("controller not idle after cursor advance");

endmodule

`default_nettype wire

>>> sv/scaled_glyph_span_generator.sv
// top level: a load beat writes one glyph store row; a draw first scans every glyph row,
// then fetches the glyph rows in order up to the last inked one, skipping blank rows
// and emitting scale spans per inked row, and last advances the cursor.
// the scan reads the glyph store one row per cycle, and the spans of a row leave through
// the output register one per cycle while out_ready holds; one draw is in flight at a time.
// reset clears the cursor and restores register defaults; the glyph store is not cleared.
`default_nettype none

module scaled_glyph_span_generator
  import sgsg_pkg::*;
#(
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256,
  parameter int MAX_SCALE    = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  sgsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .st        (st),
    .cmd       (cmd)
  );

  sgsg_dp #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .GLYPH_COUNT  (GLYPH_COUNT),
    .MAX_SCALE    (MAX_SCALE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

>>> dv/glyph_span_sb_pkg.sv
// scoreboard class: span prediction for draw beats and in-order result checking
package glyph_span_sb_pkg;
  import sgsg_pkg::*;

  class span_scoreboard;
    localparam int ROWS = 16;
    localparam int MAX_ZOOM = 4;

    logic [7:0]         glyph_rows [ROWS*256];
    logic [COORD_W-1:0] cursor_x;
    logic [COORD_W-1:0] cursor_y;
    logic [SCALE_W-1:0] zoom;
    logic [31:0]        ink;
    logic [7:0]         first_code;
    logic [7:0]         last_code;
    out_item_t          expected_spans [$];
    int                 errors;

    function new();
      cursor_x   = '0;
      cursor_y   = '0;
      zoom       = SCALE_RST;
      ink        = INK_COLOR_RST;
      first_code = FIRST_CODE_RST;
      last_code  = LAST_CODE_RST;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SCALE:      zoom = data[SCALE_W-1:0];
        REG_INK_COLOR:  ink = data[31:0];
        REG_FIRST_CODE: first_code = data[7:0];
        REG_LAST_CODE:  last_code = data[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_spans.size();
    endfunction

    // each lit column becomes s adjacent mask bits, column 0 at bit 0
    function logic [MASK_W-1:0] spread_row(logic [7:0] bits, int s);
      logic [MASK_W-1:0] m;
      int b;
      m = '0;
      for (int c = 0; c < GLYPH_WIDTH; c++) begin
        if (bits[7-c]) begin
          for (int k = 0; k < s; k++) begin
            b = c * s + k;
            if (b < MASK_W) m[b] = 1'b1;
          end
        end
      end
      return m;
    endfunction

    function void note_beat(in_item_t it);
      int s;
      logic [7:0] g;
      logic [7:0] bits;
      logic [3:0] ln;
      logic [MASK_W-1:0] m;
      out_item_t span;
      out_item_t held;
      bit have_held;
      if (it.action == ACT_LOAD) begin
        glyph_rows[{it.glyph_index, it.glyph_line}] = it.row_bits;
        return;
      end
      if (it.start_text) begin
        cursor_x = {1'b0, it.pos_x};
        cursor_y = {1'b0, it.pos_y};
      end
      s = (zoom == 0) ? 1 : (int'(zoom) > MAX_ZOOM) ? MAX_ZOOM : int'(zoom);
      g = (it.char_code >= first_code && it.char_code <= last_code) ?
          it.char_code - first_code : 8'd0;
      have_held = 1'b0;
      for (int row = 0; row < ROWS; row++) begin
        ln = row[3:0];
        bits = glyph_rows[{g, ln}];
        if (bits == 8'h00) continue;
        m = spread_row(bits, s);
        for (int r = 0; r < s; r++) begin
          span.span_x     = cursor_x;
          span.span_y     = cursor_y + COORD_W'(row * s + r);
          span.span_mask  = m;
          span.span_color = ink;
          span.last_span  = 1'b0;
          if (have_held) expected_spans.push_back(held);
          held = span;
          have_held = 1'b1;
        end
      end
      if (have_held) begin
        held.last_span = 1'b1;
        expected_spans.push_back(held);
      end
      cursor_x = cursor_x + COORD_W'(GLYPH_WIDTH * s);
    endfunction

    function void check_span(out_item_t got);
      out_item_t want;
      if (expected_spans.size() == 0) begin
        $error("span with nothing expected: x=%0d y=%0d", got.span_x, got.span_y);
        errors++;
        return;
      end
      want = expected_spans.pop_front();
      if (got.span_x !== want.span_x) begin
        $error("span_x: expected %0d, actual %0d", want.span_x, got.span_x);
        errors++;
      end
      if (got.span_y !== want.span_y) begin
        $error("span_y: expected %0d, actual %0d", want.span_y, got.span_y);
        errors++;
      end
      if (got.span_mask !== want.span_mask) begin
        $error("span_mask: expected %h, actual %h", want.span_mask, got.span_mask);
        errors++;
      end
      if (got.span_color !== want.span_color) begin
        $error("span_color: expected %h, actual %h", want.span_color, got.span_color);
        errors++;
      end
      if (got.last_span !== want.last_span) begin
        $error("last_span: expected %0b, actual %0b", want.last_span, got.last_span);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> dv/tb_scaled_glyph_span_generator.sv
// testbench top: drives glyph loads and draws, checks every emitted span
module tb_scaled_glyph_span_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import sgsg_pkg::*;
  import glyph_span_sb_pkg::*;

  localparam int LIMIT = 500000;
  localparam int DRAIN = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  span_scoreboard sb;
  int cycle_count = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  logic [15:0] rows_done [256];
  logic [7:0] cur_first = FIRST_CODE_RST;
  logic [7:0] cur_last = LAST_CODE_RST;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  scaled_glyph_span_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // results first: a span seen at this edge comes from an earlier beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_span(out_data);
    if (rst_n && in_valid && in_ready) sb.note_beat(in_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: stall pattern changes per segment, with occasional long hold-offs
  initial begin
    int seg;
    int mode;
    wait (rst_n === 1'b1);
    forever begin
      seg = $urandom_range(20, 200);
      mode = $urandom_range(0, 4);
      if (hold_req || mode == 4) begin
        hold_req = 1'b0;
        @(negedge clk) out_ready <= 1'b0;
        repeat (399) @(negedge clk);
      end else begin
        repeat (seg) begin
          if (hold_req) break;
          @(negedge clk);
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 4) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  task automatic send_beat(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  function automatic in_item_t noise_beat();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [7:0] rand_row();
    return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  function automatic logic [11:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_glyph();
    logic [7:0] g;
    // glyph 1 stays blank for the whole run
    g = 8'($urandom);
    return (g == 8'd1) ? 8'd2 : g;
  endfunction

  function automatic logic [7:0] glyph_for(logic [7:0] code);
    return (code >= cur_first && code <= cur_last) ? code - cur_first : 8'd0;
  endfunction

  // only codes whose glyph has all rows loaded, so no unwritten entry is read
  function automatic logic [7:0] pick_code();
    logic [7:0] c;
    int base;
    int g;
    for (int t = 0; t < 16; t++) begin
      c = 8'($urandom);
      if (rows_done[glyph_for(c)] == 16'hFFFF) return c;
    end
    base = $urandom_range(0, 255);
    for (int i = 0; i < 256; i++) begin
      g = (base + i) % 256;
      if (rows_done[g] == 16'hFFFF && int'(cur_first) + g <= int'(cur_last))
        return 8'(int'(cur_first) + g);
    end
    if (cur_first != 8'd0) return 8'd0;
    return 8'hFF;
  endfunction

  task automatic load_row(input logic [7:0] g, input logic [3:0] ln, input logic [7:0] bits);
    in_item_t it;
    it = noise_beat();
    it.action = ACT_LOAD;
    it.glyph_index = g;
    it.glyph_line = ln;
    it.row_bits = bits;
    rows_done[g][ln] = 1'b1;
    send_beat(it);
  endtask

  task automatic load_glyph(input logic [7:0] g);
    for (int ln = 0; ln < 16; ln++) load_row(g, ln[3:0], rand_row());
  endtask

  task automatic draw(input logic [7:0] code, input logic start,
                      input logic [11:0] px, input logic [11:0] py);
    in_item_t it;
    it = noise_beat();
    it.action = ACT_DRAW;
    it.start_text = start;
    it.pos_x = px;
    it.pos_y = py;
    it.char_code = code;
    send_beat(it);
  endtask

  // idle the input, let all spans drain and the last draw finish its scan
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_regs(input logic [2:0] zoom, input logic [31:0] ink,
                          input logic [7:0] first, input logic [7:0] last);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0] idx [4];
    vals = '{CFG_DATA_W'(zoom), ink, CFG_DATA_W'(first), CFG_DATA_W'(last)};
    idx = '{REG_SCALE, REG_INK_COLOR, REG_FIRST_CODE, REG_LAST_CODE};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      sb.set_reg(idx[i], vals[i]);
    end
    @(negedge clk) cfg_we <= 1'b0;
    cur_first = first;
    cur_last = last;
  endtask

  task automatic random_phase(input logic [2:0] zoom, input logic [31:0] ink,
                              input logic [7:0] first, input logic [7:0] last,
                              input bit hold, input int n_draws);
    int draws;
    int pick;
    settle();
    set_regs(zoom, ink, first, last);
    if (hold) hold_req = 1'b1;
    draws = 0;
    while (draws < n_draws) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        load_glyph(rand_glyph());
      end else if (pick < 18) begin
        load_row(rand_glyph(), 4'($urandom), 8'($urandom));
      end else begin
        draw(pick_code(), draws == 0 || $urandom_range(0, 9) < 3, rand_pos(), rand_pos());
        draws++;
      end
    end
  endtask

  initial begin
    sb = new();
    foreach (rows_done[i]) rows_done[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // glyph 0 with edge patterns, glyph 1 blank, glyph 94 for the top default code
    load_row(8'd0, 4'd0, 8'h80);
    load_row(8'd0, 4'd1, 8'h01);
    load_row(8'd0, 4'd2, 8'hFF);
    load_row(8'd0, 4'd3, 8'h00);
    for (int ln = 4; ln < 16; ln++) load_row(8'd0, ln[3:0], rand_row());
    for (int ln = 0; ln < 16; ln++) load_row(8'd1, ln[3:0], 8'h00);
    load_glyph(8'd94);

    // defaults: scale 1, codes 32..126
    draw(8'd32, 1'b1, 12'd0, 12'd0);
    draw(8'd33, 1'b0, 12'd0, 12'd0);
    draw(8'd126, 1'b0, 12'd0, 12'd0);
    draw(8'd127, 1'b0, 12'd0, 12'd0);
    draw(8'd31, 1'b1, 12'hFFF, 12'hFFF);
    draw(8'd0, 1'b0, 12'd5, 12'd5);
    draw(8'd255, 1'b0, 12'd5, 12'd5);
    load_row(8'd0, 4'd5, 8'hAA);
    draw(8'd32, 1'b1, 12'd2048, 12'd17);

    random_phase(3'd0, 32'hFFFF_FFFF, 8'd0, 8'd255, 1'b1, 6);
    random_phase(3'd4, 32'($urandom), 8'd200, 8'd100, 1'b0, 4);
    random_phase(3'd7, 32'd0, 8'd255, 8'd255, 1'b0, 4);
    random_phase(3'd2, 32'($urandom), 8'd10, 8'd60, 1'b0, 4);
    random_phase(3'd3, 32'($urandom), 8'd0, 8'd127, 1'b0, 4);

    // blank glyphs at scale 4 still move the cursor past the top column
    settle();
    set_regs(3'd4, 32'h00C0_FFEE, 8'd0, 8'd255);
    draw(8'd1, 1'b1, 12'hFFF, 12'd100);
    draw(8'd1, 1'b0, 12'd0, 12'd0);
    draw(8'd0, 1'b0, 12'd0, 12'd0);

    settle();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
